// File: rtl/sorl_pkg.sv
// Shared types, sizes and a helper function of the sequenced overwrite ring log.
// Depends on nothing; used by the top level, which also passes the sizes to the ring RAM.
package sorl_pkg;

  localparam int CAPACITY    = 64;
  localparam int ENTRY_WIDTH = 64;

  localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int SEQ_W      = 32;
  localparam int WORD_W     = 64;
  localparam int RETAINED_W = 7;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_SINCE  = 2'd1;
  localparam logic [1:0] MODE_ALL    = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [SEQ_W-1:0]       seq_t;
  typedef logic [ENTRY_WIDTH-1:0] entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_STREAM
  } state_t;

  // Slot after s, wrapping at the ring capacity.
  function automatic slot_t next_slot(input slot_t s);
    slot_t r;
    if (s == SLOT_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/sorl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; holds the ring entries of the log.
module sorl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sequenced_overwrite_ring_log.sv
// Sequenced overwrite ring log: ring of entry words with 32-bit sequence numbers.
// Append: result in the next cycle; busy stays low, so one append per cycle when idle.
// Replay: S_SETUP issues the first read, then S_STREAM reads one word per cycle
// from the single read port of the ring RAM; busy falls as the last word is read.
// Reset (rst, synchronous) clears counters and the sequencer; the ring RAM is not cleared.
// Results are strobed for one cycle each and the receiver cannot stall them.
module sequenced_overwrite_ring_log (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [63:0] entry_in,
  input  logic [31:0] from_sequence,
  output logic        strobe,
  output logic        has_entry,
  output logic [63:0] entry_out,
  output logic [31:0] next_sequence,
  output logic [31:0] total_written,
  output logic [6:0]  retained,
  output logic        last
);

  sorl_pkg::state_t state;
  sorl_pkg::state_t state_next;

  sorl_pkg::slot_t  write_slot;
  sorl_pkg::slot_t  oldest_slot;
  sorl_pkg::slot_t  rd_slot;
  sorl_pkg::count_t held_count;
  sorl_pkg::seq_t   seq_counter;
  sorl_pkg::seq_t   oldest_seq;
  sorl_pkg::seq_t   cur_seq;
  logic [1:0]       req_mode;

  logic                      accept;
  sorl_pkg::seq_t            clamp_start;
  sorl_pkg::seq_t            seq_after;
  logic                      at_end;
  logic                      setup_empty;
  sorl_pkg::seq_t            seq_offset;
  logic [sorl_pkg::SLOT_W:0] slot_sum;
  sorl_pkg::slot_t           first_slot;
  logic                      ram_re;
  sorl_pkg::slot_t           ram_raddr;
  logic                      ram_we;
  sorl_pkg::entry_t          ram_rdata;

  assign busy          = (state != sorl_pkg::S_IDLE);
  assign accept        = start && !busy;
  assign total_written = seq_counter;
  assign retained      = sorl_pkg::RETAINED_W'(held_count);
  assign entry_out     = has_entry ? sorl_pkg::WORD_W'(ram_rdata) : '0;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sorl_pkg::S_IDLE: begin
        if (accept && (mode inside {sorl_pkg::MODE_SINCE, sorl_pkg::MODE_ALL})) begin
          state_next = sorl_pkg::S_SETUP;
        end
      end
      sorl_pkg::S_SETUP: begin
        if (setup_empty || at_end) begin
          state_next = sorl_pkg::S_IDLE;
        end else begin
          state_next = sorl_pkg::S_STREAM;
        end
      end
      sorl_pkg::S_STREAM: begin
        if (at_end) begin
          state_next = sorl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sorl_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer controls and address arithmetic.
  always_comb begin
    clamp_start = (from_sequence < oldest_seq) ? oldest_seq : from_sequence;
    seq_after   = cur_seq + sorl_pkg::seq_t'(1);
    at_end      = (seq_after == seq_counter);
    if (req_mode == sorl_pkg::MODE_ALL) begin
      setup_empty = (held_count == '0);
    end else begin
      setup_empty = !(cur_seq < seq_counter);
    end
    // A non-empty replay starts less than one ring length past the oldest entry.
    seq_offset = cur_seq - oldest_seq;
    slot_sum   = {1'b0, oldest_slot} + {1'b0, seq_offset[sorl_pkg::SLOT_W-1:0]};
    if (slot_sum >= (sorl_pkg::SLOT_W + 1)'(sorl_pkg::CAPACITY)) begin
      first_slot = sorl_pkg::SLOT_W'(slot_sum - (sorl_pkg::SLOT_W + 1)'(sorl_pkg::CAPACITY));
    end else begin
      first_slot = slot_sum[sorl_pkg::SLOT_W-1:0];
    end
    ram_we    = accept && (mode == sorl_pkg::MODE_APPEND);
    ram_raddr = (state == sorl_pkg::S_SETUP) ? first_slot : rd_slot;
    ram_re    = ((state == sorl_pkg::S_SETUP) && !setup_empty) ||
                (state == sorl_pkg::S_STREAM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sorl_pkg::S_IDLE;
      write_slot  <= '0;
      oldest_slot <= '0;
      held_count  <= '0;
      seq_counter <= '0;
      oldest_seq  <= '0;
      strobe      <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      if (accept) begin
        case (mode)
          sorl_pkg::MODE_APPEND: begin
            write_slot  <= sorl_pkg::next_slot(write_slot);
            seq_counter <= seq_counter + sorl_pkg::seq_t'(1);
            if (held_count == sorl_pkg::COUNT_W'(sorl_pkg::CAPACITY)) begin
              // Full ring: the oldest word is overwritten and the window slides.
              oldest_slot <= sorl_pkg::next_slot(write_slot);
              oldest_seq  <= oldest_seq + sorl_pkg::seq_t'(1);
            end else begin
              held_count <= held_count + sorl_pkg::count_t'(1);
            end
            strobe        <= 1'b1;
            has_entry     <= 1'b0;
            next_sequence <= seq_counter + sorl_pkg::seq_t'(1);
            last          <= 1'b1;
          end
          sorl_pkg::MODE_SINCE: begin
            req_mode <= mode;
            cur_seq  <= clamp_start;
          end
          sorl_pkg::MODE_ALL: begin
            req_mode <= mode;
            cur_seq  <= oldest_seq;
          end
          default: begin
            strobe        <= 1'b1;
            has_entry     <= 1'b0;
            next_sequence <= seq_counter;
            last          <= 1'b1;
          end
        endcase
      end
      if ((state == sorl_pkg::S_SETUP) && setup_empty) begin
        strobe        <= 1'b1;
        has_entry     <= 1'b0;
        next_sequence <= cur_seq;
        last          <= 1'b1;
      end
      // The result word leaves the RAM in the cycle after its read is issued,
      // together with the metadata registered here.
      if (ram_re) begin
        strobe        <= 1'b1;
        has_entry     <= 1'b1;
        next_sequence <= seq_after;
        last          <= at_end;
        cur_seq       <= seq_after;
        rd_slot       <= sorl_pkg::next_slot(ram_raddr);
      end
    end
  end

  sorl_ram #(
    .WIDTH (sorl_pkg::ENTRY_WIDTH),
    .DEPTH (sorl_pkg::CAPACITY)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (entry_in[sorl_pkg::ENTRY_WIDTH-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
